@@ rtl/core/ssdg_pkg.sv @@
// Shared types and constants for the stepper step/direction generator.
// Holds the command codes, field widths and the packed input and result items.
// No dependencies; every other file in rtl/core imports this package.
package ssdg_pkg;

  // Field and state widths.
  localparam int CMD_W     = 2;
  localparam int SPEED_W   = 16;
  localparam int MAG_W     = 16;
  localparam int HALF_W    = 19;
  localparam int ELAPSED_W = 20;

  // Default numerator of the half-period division, in microseconds times hertz.
  localparam logic [HALF_W-1:0] HALF_PERIOD_NUMERATOR_DEF = 19'd500000;

  // Command codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPEED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [SPEED_W-1:0] speed_hz;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic running;
  } out_item_t;

endpackage

@@ rtl/core/ssdg_divider.sv @@
// Iterative restoring divider that turns a speed magnitude into a half period.
// Produces one quotient bit per cycle; depends on ssdg_pkg for the widths.
module ssdg_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ssdg_pkg::HALF_W-1:0]  dividend,
  input  logic [ssdg_pkg::MAG_W-1:0]   divisor,
  output logic                         done,
  output logic [ssdg_pkg::HALF_W-1:0]  quotient
);
  import ssdg_pkg::*;

  localparam int CNT_W = $clog2(HALF_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HALF_W - 1);

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } dv_state_t;

  dv_state_t          state_r;
  logic [MAG_W-1:0]   rem_r;
  logic [HALF_W-1:0]  quo_r;
  logic [MAG_W-1:0]   dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;

  logic [MAG_W:0]     shifted;
  logic [MAG_W-1:0]   diff;
  logic               fits;
  logic [MAG_W-1:0]   rem_nxt;

  // One restoring step: bring down the next dividend bit and try the subtract.
  // When the subtract fits, the difference is below the divisor, so the low
  // bits carry all of it.
  always_comb begin
    shifted = {rem_r, quo_r[HALF_W-1]};
    diff    = shifted[MAG_W-1:0] - dvs_r;
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? diff : shifted[MAG_W-1:0];
  end

  // Sequencer, partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        DV_IDLE: begin
          if (start) begin
            rem_r   <= '0;
            quo_r   <= dividend;
            dvs_r   <= divisor;
            cnt_r   <= '0;
            state_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[HALF_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            done_r  <= 1'b1;
            state_r <= DV_IDLE;
          end
        end
        default: begin
          state_r <= DV_IDLE;
        end
      endcase
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // A completion pulse only follows the last iteration of a run.
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == DV_RUN) && ($past(cnt_r) == CNT_LAST))
    else $error("divider done without a finished run");

  // The quotient is stable while no run is in progress.
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DV_IDLE) && !start |=> $stable(quo_r))
    else $error("divider quotient changed while idle");

  // The remainder always stays below the divisor during a run.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DV_RUN) && (dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

endmodule

@@ rtl/core/stepper_step_dir_generator_unit.sv @@
// Stepper step/direction generator: one result per transfer on the input channel.
// A tick, a stop or a zero speed is handled without the divider: the input is accepted
// whenever the block is idle and the output register is empty or being taken,
// and the result is registered at the accepting edge and offered in the next
// cycle. A nonzero set-speed transfer runs HALF_W (19) iterations of the
// restoring divider to form the half period. The quotient is registered as the
// half period when the divider is done, the emit state registers the result once
// the output is free, and the input stays not ready until the block is idle again.
// The divider's one-bit-per-cycle loop sets how long a division runs. The direction
// pin follows the sign of a nonzero speed at acceptance, XORed with the invert
// bit; the step pin toggles when the elapsed microsecond count reaches the half
// period, and stop forces the step pin low while keeping the internal toggle phase.
// Depends on ssdg_pkg and ssdg_divider.
module stepper_step_dir_generator_unit #(
  parameter logic [ssdg_pkg::HALF_W-1:0] HALF_PERIOD_NUMERATOR =
    ssdg_pkg::HALF_PERIOD_NUMERATOR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssdg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssdg_pkg::out_item_t out_data
);
  import ssdg_pkg::*;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic                  invert_r;
  logic [HALF_W-1:0]     half_r, half_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic                  phase_r, phase_nxt;
  logic                  step_r, step_nxt;
  logic                  dir_r, dir_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  emit;
  logic                  speed_neg;
  logic [MAG_W-1:0]      speed_mag;
  logic [ELAPSED_W-1:0]  elapsed_inc;
  logic                  div_start;
  logic                  div_done;
  logic [HALF_W-1:0]     div_quotient;

  // Restoring divider, numerator over speed magnitude.
  ssdg_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (HALF_PERIOD_NUMERATOR),
    .divisor  (speed_mag),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Handshake terms.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // Speed sign and magnitude; the most negative speed maps to 32768.
  assign speed_neg = in_data.speed_hz[SPEED_W-1];
  assign speed_mag = speed_neg ? MAG_W'(-in_data.speed_hz) : MAG_W'(in_data.speed_hz);

  // Saturating elapsed count for a tick.
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  // Command decode and result formation.
  always_comb begin
    state_nxt     = state_r;
    half_nxt      = half_r;
    elapsed_nxt   = elapsed_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    emit          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            CMD_TICK: begin
              elapsed_nxt = elapsed_inc;
              if ((half_r != '0) && (elapsed_inc >= {1'b0, half_r})) begin
                elapsed_nxt = '0;
                phase_nxt   = ~phase_r;
                step_nxt    = ~phase_r;
              end
              emit = 1'b1;
            end
            CMD_SPEED: begin
              if (in_data.speed_hz != '0) begin
                dir_nxt = ~speed_neg ^ invert_r;
              end
              if (speed_mag == '0) begin
                half_nxt = '0;
                emit     = 1'b1;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            CMD_STOP: begin
              half_nxt = '0;
              step_nxt = 1'b0;
              emit     = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          half_nxt  = div_quotient;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.step_level = step_nxt;
      out_data_nxt.dir_level  = dir_nxt;
      out_data_nxt.running    = (half_nxt != '0);
    end
  end

  // State, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      invert_r    <= 1'b0;
      half_r      <= '0;
      elapsed_r   <= '0;
      phase_r     <= 1'b0;
      step_r      <= 1'b0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      half_r      <= half_nxt;
      elapsed_r   <= elapsed_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        invert_r <= cfg_wdata;
      end
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stop transfer always reports a low step pin and no stepping.
  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.cmd == CMD_STOP) |=>
      out_valid_r && !out_data_r.step_level && !out_data_r.running)
    else $error("stop result shows stepping");

  // The step pin is only high while the toggle phase is high.
  a_step_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_r |-> phase_r)
    else $error("step pin high with low toggle phase");

  // A nonzero set-speed transfer starts a division.
  a_speed_divides: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.cmd == CMD_SPEED) && (in_data.speed_hz != '0) |=>
      (state_r == ST_DIV))
    else $error("set speed did not start the divider");

  // The divider only finishes while a division is pending.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside a division");

endmodule

@@ verif/stepper_step_dir_generator_unit_tb.sv @@
// Self-checking testbench for stepper_step_dir_generator_unit: directed table, random mix
// and a short closing run at full rate with the direction inverted.
// Depends on ssdg_pkg and the generator RTL; checks use a local pin model or typed rows.
`timescale 1ns / 1ps

module stepper_step_dir_generator_unit_tb;
  import ssdg_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 30;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int PLAN_ROWS    = 24;
  localparam int RAND_PHASES  = 4;
  localparam int RAND_CHUNK   = 38;
  localparam int CHUNKS       = 6;

  // Code 3 is not decoded by the block and must leave the state alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One row of the directed plan: a command repeated reps times.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    int               speed;
    int               reps;
    bit               typed;
    out_item_t        want;
  } drive_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Hand-typed expectation that travels with the presented item.
  bit        in_typed = 1'b0;
  out_item_t in_want = '0;

  bit        full_rate = 1'b0;
  int        stall_left = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  out_item_t pending_levels[$];
  drive_row_t plan [PLAN_ROWS];

  // Local copy of the generator state.
  logic [HALF_W-1:0]    half_us = '0;
  logic [ELAPSED_W-1:0] elapsed = '0;
  logic                 phase = 1'b0;
  logic                 step_lvl = 1'b0;
  logic                 dir_lvl = 1'b0;
  logic                 invert = 1'b0;

  stepper_step_dir_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Advance the pin model by one item and return the levels it shows afterwards.
  function automatic out_item_t predict_pins(in_item_t it);
    logic [SPEED_W-1:0] bits;
    logic [SPEED_W:0]   mag;
    out_item_t          res;
    bits = it.speed_hz;
    case (it.cmd)
      CMD_TICK: begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (half_us != '0 && {1'b0, elapsed} >= {2'b00, half_us}) begin
          elapsed  = '0;
          phase    = ~phase;
          step_lvl = phase;
        end
      end
      CMD_SPEED: begin
        mag = bits[SPEED_W-1] ? (17'h10000 - {1'b0, bits}) : {1'b0, bits};
        if (bits != '0) dir_lvl = ~bits[SPEED_W-1] ^ invert;
        if (mag == '0) half_us = '0;
        else half_us = HALF_W'(32'(HALF_PERIOD_NUMERATOR_DEF) / 32'(mag));
      end
      CMD_STOP: begin
        half_us  = '0;
        step_lvl = 1'b0;
      end
      default: begin
      end
    endcase
    res.step_level = step_lvl;
    res.dir_level  = dir_lvl;
    res.running    = (half_us != '0);
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Idle length: most gaps short, a few long.
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (full_rate || $urandom_range(0, 99) < 55) return 0;
    return pick_stall();
  endfunction

  // Random item: mostly ticks and fast speeds so the step pin toggles often.
  function automatic in_item_t rand_item();
    in_item_t it;
    int       r;
    int       sel;
    int       mag;
    int       v;
    r = $urandom_range(0, 99);
    it.speed_hz = SPEED_W'($urandom());
    if (r < 70) begin
      it.cmd = CMD_TICK;
    end else if (r < 86) begin
      it.cmd = CMD_SPEED;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        mag = $urandom_range(8000, 32767);
        v = $urandom_range(0, 1) ? -mag : mag;
        it.speed_hz = SPEED_W'(v);
      end else if (sel < 80) begin
        it.speed_hz = SPEED_W'($urandom());
      end else if (sel < 88) begin
        it.speed_hz = '0;
      end else if (sel < 96) begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 1;
          default: v = -1;
        endcase
        it.speed_hz = SPEED_W'(v);
      end else begin
        mag = $urandom_range(1000, 8000);
        v = $urandom_range(0, 1) ? -mag : mag;
        it.speed_hz = SPEED_W'(v);
      end
    end else if (r < 95) begin
      it.cmd = CMD_STOP;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // Present one item after gap idle cycles and hold it until the transfer.
  task automatic send_item(in_item_t item, int gap, bit typed, out_item_t want);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    in_typed <= typed;
    in_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register writes happen only once every result is back and the block has settled.
  task automatic set_invert(bit value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result-side back-pressure.
  always @(negedge clk) begin
    if (full_rate) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 30) begin
      stall_left = pick_stall() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    if (!rst_n) begin
      half_us  = '0;
      elapsed  = '0;
      phase    = 1'b0;
      step_lvl = 1'b0;
      dir_lvl  = 1'b0;
      invert   = 1'b0;
    end else begin
      if (cfg_we) invert = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pending_levels.size() == 0) begin
          report_mismatch("unexpected result transfer", 0, int'(out_data));
        end else begin
          want = pending_levels.pop_front();
          if (out_data.step_level !== want.step_level)
            report_mismatch("step_level", want.step_level, out_data.step_level);
          if (out_data.dir_level !== want.dir_level)
            report_mismatch("dir_level", want.dir_level, out_data.dir_level);
          if (out_data.running !== want.running)
            report_mismatch("running", want.running, out_data.running);
        end
      end
      if (in_valid && in_ready) begin
        pred = predict_pins(in_data);
        pending_levels.push_back(in_typed ? in_want : pred);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int       ph;
    int       ch;
    int       n;
    int       r;

    // Directed plan; typed results are step, dir, running.
    plan[0]  = '{CMD_TICK,   0,      1,  1'b1, 3'b000};
    plan[1]  = '{CMD_UNUSED, 0,      1,  1'b1, 3'b000};
    plan[2]  = '{CMD_STOP,   0,      1,  1'b1, 3'b000};
    plan[3]  = '{CMD_SPEED,  32767,  1,  1'b1, 3'b011};
    plan[4]  = '{CMD_SPEED,  -32768, 1,  1'b1, 3'b001};
    plan[5]  = '{CMD_TICK,   0,      16, 1'b0, 3'b000};
    plan[6]  = '{CMD_SPEED,  0,      1,  1'b0, 3'b000};
    plan[7]  = '{CMD_TICK,   0,      5,  1'b0, 3'b000};
    plan[8]  = '{CMD_SPEED,  1,      1,  1'b0, 3'b000};
    plan[9]  = '{CMD_SPEED,  -1,     1,  1'b0, 3'b000};
    plan[10] = '{CMD_STOP,   0,      1,  1'b1, 3'b000};
    plan[11] = '{CMD_TICK,   0,      40, 1'b0, 3'b000};
    plan[12] = '{CMD_SPEED,  16384,  1,  1'b0, 3'b000};
    plan[13] = '{CMD_TICK,   0,      1,  1'b0, 3'b000};
    plan[14] = '{CMD_TICK,   0,      70, 1'b0, 3'b000};
    plan[15] = '{CMD_SPEED,  -12345, 1,  1'b0, 3'b000};
    plan[16] = '{CMD_TICK,   0,      90, 1'b0, 3'b000};
    plan[17] = '{CMD_SPEED,  21845,  1,  1'b0, 3'b000};
    plan[18] = '{CMD_TICK,   0,      50, 1'b0, 3'b000};
    plan[19] = '{CMD_SPEED,  -21846, 1,  1'b0, 3'b000};
    plan[20] = '{CMD_TICK,   0,      50, 1'b0, 3'b000};
    plan[21] = '{CMD_UNUSED, -1,     1,  1'b0, 3'b000};
    plan[22] = '{CMD_SPEED,  255,    1,  1'b0, 3'b000};
    plan[23] = '{CMD_STOP,   0,      1,  1'b0, 3'b000};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    set_invert(1'b0);

    // Directed part.
    for (r = 0; r < PLAN_ROWS; r++) begin
      it.cmd      = plan[r].cmd;
      it.speed_hz = SPEED_W'(plan[r].speed);
      repeat (plan[r].reps) send_item(it, pick_gap(), plan[r].typed, plan[r].want);
    end

    // Random part, alternating the direction inversion between phases.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_invert(ph[0] == 1'b0);
      for (ch = 0; ch < CHUNKS; ch++) begin
        full_rate <= ($urandom_range(0, 3) == 0);
        for (n = 0; n < RAND_CHUNK; n++) send_item(rand_item(), pick_gap(), 1'b0, '0);
      end
    end

    // Closing run at full rate with the direction inverted: stop, the slowest
    // speed, a few ticks, the most negative speed and a burst of ticks.
    set_invert(1'b1);
    full_rate <= 1'b1;
    it.cmd      = CMD_STOP;
    it.speed_hz = '0;
    send_item(it, 0, 1'b0, '0);
    it.cmd      = CMD_SPEED;
    it.speed_hz = SPEED_W'(1);
    send_item(it, 0, 1'b0, '0);
    it.cmd = CMD_TICK;
    repeat (3) send_item(it, 0, 1'b0, '0);
    it.cmd      = CMD_SPEED;
    it.speed_hz = SPEED_W'(-32768);
    send_item(it, 0, 1'b0, '0);
    it.cmd = CMD_TICK;
    repeat (20) send_item(it, 0, 1'b0, '0);

    @(negedge clk);
    in_valid  <= 1'b0;
    full_rate <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
